/* rtl/alu8f_pkg.sv */
// Package with the operation codes, flag bit positions and field widths of the ALU.
`default_nettype none
package alu8f_pkg;

  localparam int unsigned FUNC_W = 5;
  localparam int unsigned WORD_W = 16;
  localparam int unsigned FLAG_W = 8;

  typedef logic [FUNC_W-1:0] func_t;
  typedef logic [WORD_W-1:0] word_t;
  typedef logic [FLAG_W-1:0] flag_t;
  typedef logic [7:0]        byte_t;

  // Operation codes.
  localparam func_t FN_ADD   = 5'd0;
  localparam func_t FN_ADC   = 5'd1;
  localparam func_t FN_SUB   = 5'd2;
  localparam func_t FN_SBC   = 5'd3;
  localparam func_t FN_AND   = 5'd4;
  localparam func_t FN_XOR   = 5'd5;
  localparam func_t FN_OR    = 5'd6;
  localparam func_t FN_CP    = 5'd7;
  localparam func_t FN_INC   = 5'd8;
  localparam func_t FN_DEC   = 5'd9;
  localparam func_t FN_RLCA  = 5'd10;
  localparam func_t FN_RRCA  = 5'd11;
  localparam func_t FN_RLA   = 5'd12;
  localparam func_t FN_RRA   = 5'd13;
  localparam func_t FN_DAA   = 5'd14;
  localparam func_t FN_CPL   = 5'd15;
  localparam func_t FN_SCF   = 5'd16;
  localparam func_t FN_CCF   = 5'd17;
  localparam func_t FN_ADD16 = 5'd18;

  // Flag bit positions.
  localparam int unsigned FB_S  = 7;
  localparam int unsigned FB_Z  = 6;
  localparam int unsigned FB_5  = 5;
  localparam int unsigned FB_H  = 4;
  localparam int unsigned FB_3  = 3;
  localparam int unsigned FB_PV = 2;
  localparam int unsigned FB_N  = 1;
  localparam int unsigned FB_C  = 0;

  // Flag masks.
  localparam flag_t FM_KEEP_SZP = 8'hC4;
  localparam flag_t FM_XY       = 8'h28;
  localparam flag_t FM_H        = 8'h10;

endpackage
`default_nettype wire

/* rtl/alu8f_core.sv */
// Combinational datapath of the ALU: result value and new flag byte for one word.
`default_nettype none
module alu8f_core (
  input  wire alu8f_pkg::func_t func,
  input  wire alu8f_pkg::word_t operand_a,
  input  wire alu8f_pkg::word_t operand_b,
  input  wire alu8f_pkg::flag_t flags_in,
  output alu8f_pkg::word_t      result,
  output alu8f_pkg::flag_t      flags_out
);
  import alu8f_pkg::*;

  function automatic flag_t szxy(input byte_t r);
    flag_t f;
    f = 8'h00;
    f[FB_S] = r[7];
    f[FB_Z] = (r == 8'h00);
    f[FB_5] = r[5];
    f[FB_3] = r[3];
    return f;
  endfunction

  function automatic flag_t parity(input byte_t r);
    flag_t f;
    f = 8'h00;
    f[FB_PV] = ~^r;
    return f;
  endfunction

  byte_t    a;
  byte_t    b;
  logic     cin;
  logic     add_c;
  logic     sub_c;
  logic [8:0] add_full;
  logic [4:0] add_half;
  logic [8:0] sub_full;
  logic [4:0] sub_half;
  byte_t    add_r;
  byte_t    sub_r;
  flag_t    add_f;
  flag_t    sub_f;
  logic     daa_hi;
  logic     daa_lo;
  byte_t    daa_t;
  byte_t    daa_r;
  logic [16:0] sum16;
  word_t    r16;
  byte_t    rb;
  flag_t    f;

  assign a   = operand_a[7:0];
  assign b   = operand_b[7:0];
  assign cin = flags_in[FB_C];

  // The adder and the subtractor are each shared by their carry and no-carry forms.
  assign add_c    = (func == FN_ADC) ? cin : 1'b0;
  assign sub_c    = (func == FN_SBC) ? cin : 1'b0;
  assign add_full = {1'b0, a} + {1'b0, b} + {8'h00, add_c};
  assign add_half = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'h0, add_c};
  assign sub_full = {1'b0, a} - {1'b0, b} - {8'h00, sub_c};
  assign sub_half = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'h0, sub_c};
  assign add_r    = add_full[7:0];
  assign sub_r    = sub_full[7:0];

  always_comb begin
    add_f        = szxy(add_r);
    add_f[FB_H]  = add_half[4];
    add_f[FB_PV] = (a[7] ^ add_r[7]) & (b[7] ^ add_r[7]);
    add_f[FB_C]  = add_full[8];
    sub_f        = szxy(sub_r);
    sub_f[FB_N]  = 1'b1;
    sub_f[FB_H]  = sub_half[4];
    sub_f[FB_PV] = (a[7] ^ b[7]) & (a[7] ^ sub_r[7]);
    sub_f[FB_C]  = sub_full[8];
  end

  // Decimal adjust: the correction is added or subtracted as the N flag says.
  assign daa_hi = (a > 8'h99) | cin;
  assign daa_lo = (a[3:0] > 4'h9) | flags_in[FB_H];
  assign daa_t  = (daa_hi ? 8'h60 : 8'h00) | (daa_lo ? 8'h06 : 8'h00);
  assign daa_r  = flags_in[FB_N] ? (a - daa_t) : (a + daa_t);

  assign sum16 = {1'b0, operand_a} + {1'b0, operand_b};

  always_comb begin
    r16 = operand_a;
    rb  = 8'h00;
    f   = flags_in;
    unique case (func)
      FN_ADD, FN_ADC: begin
        r16 = {8'h00, add_r};
        f   = add_f;
      end
      FN_SUB, FN_SBC: begin
        r16 = {8'h00, sub_r};
        f   = sub_f;
      end
      FN_AND: begin
        rb        = a & b;
        r16       = {8'h00, rb};
        f         = szxy(rb) | parity(rb);
        f[FB_H]   = 1'b1;
      end
      FN_XOR: begin
        rb  = a ^ b;
        r16 = {8'h00, rb};
        f   = szxy(rb) | parity(rb);
      end
      FN_OR: begin
        rb  = a | b;
        r16 = {8'h00, rb};
        f   = szxy(rb) | parity(rb);
      end
      FN_CP: begin
        // Compare takes the undocumented bits from the operand, not the difference.
        r16 = {8'h00, a};
        f   = (sub_f & ~FM_XY) | (b & FM_XY);
      end
      FN_INC: begin
        rb        = a + 8'h01;
        r16       = {8'h00, rb};
        f         = szxy(rb);
        f[FB_C]   = cin;
        f[FB_H]   = (a[3:0] == 4'hF);
        f[FB_PV]  = (a == 8'h7F);
      end
      FN_DEC: begin
        rb        = a - 8'h01;
        r16       = {8'h00, rb};
        f         = szxy(rb);
        f[FB_C]   = cin;
        f[FB_N]   = 1'b1;
        f[FB_H]   = (a[3:0] == 4'h0);
        f[FB_PV]  = (a == 8'h80);
      end
      FN_RLCA: begin
        rb      = {a[6:0], a[7]};
        r16     = {8'h00, rb};
        f       = (flags_in & FM_KEEP_SZP) | (rb & FM_XY);
        f[FB_C] = a[7];
      end
      FN_RRCA: begin
        rb      = {a[0], a[7:1]};
        r16     = {8'h00, rb};
        f       = (flags_in & FM_KEEP_SZP) | (rb & FM_XY);
        f[FB_C] = a[0];
      end
      FN_RLA: begin
        rb      = {a[6:0], cin};
        r16     = {8'h00, rb};
        f       = (flags_in & FM_KEEP_SZP) | (rb & FM_XY);
        f[FB_C] = a[7];
      end
      FN_RRA: begin
        rb      = {cin, a[7:1]};
        r16     = {8'h00, rb};
        f       = (flags_in & FM_KEEP_SZP) | (rb & FM_XY);
        f[FB_C] = a[0];
      end
      FN_DAA: begin
        r16     = {8'h00, daa_r};
        f       = szxy(daa_r) | parity(daa_r) | ((a ^ daa_r) & FM_H);
        f[FB_N] = flags_in[FB_N];
        f[FB_C] = daa_hi;
      end
      FN_CPL: begin
        rb      = ~a;
        r16     = {8'h00, rb};
        f       = (flags_in & FM_KEEP_SZP) | (rb & FM_XY);
        f[FB_C] = cin;
        f[FB_H] = 1'b1;
        f[FB_N] = 1'b1;
      end
      FN_SCF: begin
        r16     = {8'h00, a};
        f       = (flags_in & FM_KEEP_SZP) | (a & FM_XY);
        f[FB_C] = 1'b1;
      end
      FN_CCF: begin
        r16     = {8'h00, a};
        f       = (flags_in & FM_KEEP_SZP) | (a & FM_XY);
        f[FB_H] = cin;
        f[FB_C] = ~cin;
      end
      FN_ADD16: begin
        r16     = sum16[15:0];
        // H is the carry into bit 12, recovered from the sum and both operands.
        f       = (flags_in & FM_KEEP_SZP) | (sum16[15:8] & FM_XY);
        f[FB_H] = operand_a[12] ^ operand_b[12] ^ sum16[12];
        f[FB_C] = sum16[16];
      end
      default: begin
        r16 = operand_a;
        f   = flags_in;
      end
    endcase
  end

  assign result    = r16;
  assign flags_out = f;

endmodule
`default_nettype wire

/* rtl/eight_bit_alu_with_flags.sv */
// Top level of the eight-bit ALU with flags: input register, datapath, result register.
// A word accepted into the input register goes through the datapath to the result register,
// which drives the out_ ports for the receiver.
// Throughput: one word per cycle; busy is never raised, since the datapath is a single pass.
// out_valid is a one-cycle strobe and the receiver cannot stall it.
// Reset (rst_n low, synchronous) drops the pending input and the result strobe.
`default_nettype none
module eight_bit_alu_with_flags (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   start,
  output logic                  busy,
  input  wire alu8f_pkg::func_t in_func,
  input  wire alu8f_pkg::word_t in_operand_a,
  input  wire alu8f_pkg::word_t in_operand_b,
  input  wire alu8f_pkg::flag_t in_flags_in,
  output logic                  out_valid,
  output alu8f_pkg::word_t      out_result,
  output alu8f_pkg::flag_t      out_flags_out
);
  import alu8f_pkg::*;

  logic  in_vld_r;
  func_t func_r;
  word_t a_r;
  word_t b_r;
  flag_t fi_r;
  logic  out_vld_r;
  word_t result_r;
  flag_t flags_r;
  word_t core_result;
  flag_t core_flags;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= start & ~busy;
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start & ~busy) begin
      func_r <= in_func;
      a_r    <= in_operand_a;
      b_r    <= in_operand_b;
      fi_r   <= in_flags_in;
    end
    if (in_vld_r) begin
      result_r <= core_result;
      flags_r  <= core_flags;
    end
  end

  alu8f_core u_core (
    .func      (func_r),
    .operand_a (a_r),
    .operand_b (b_r),
    .flags_in  (fi_r),
    .result    (core_result),
    .flags_out (core_flags)
  );

  assign out_valid     = out_vld_r;
  assign out_result    = result_r;
  assign out_flags_out = flags_r;

endmodule
`default_nettype wire

/* dv/eight_bit_alu_with_flags_tb.sv */
// Self-checking testbench for the eight-bit ALU with flags: directed corners, then random words.
`timescale 1ns / 100ps
module eight_bit_alu_with_flags_tb;
  import alu8f_pkg::*;

  localparam func_t FN_FIRST_UNUSED = FN_ADD16 + 5'd1;
  localparam func_t FN_LAST_UNUSED  = '1;
  localparam int unsigned WORDS_PER_PHASE = 475;

  typedef struct packed {
    func_t fn;
    word_t result;
    flag_t flags;
  } alu_outcome_t;

  class alu_outcome_board;
    alu_outcome_t pending_outcomes[$];
    int unsigned  mismatch_cnt;
    int unsigned  words_noted;
    int unsigned  results_checked;
    logic [31:0]  ops_seen;

    function flag_t flags_szxy(byte_t r);
      flag_t f;
      f        = '0;
      f[FB_S]  = r[7];
      f[FB_Z]  = (r == 8'h00);
      f[FB_5]  = r[5];
      f[FB_3]  = r[3];
      return f;
    endfunction

    function alu_outcome_t predict_outcome(func_t fn, word_t wa, word_t wb, flag_t fi);
      alu_outcome_t o;
      byte_t        a;
      byte_t        b;
      byte_t        r8;
      byte_t        adj;
      logic         cy;
      logic [8:0]   wide9;
      logic [4:0]   nib5;
      logic [16:0]  sum17;
      flag_t        f;
      a     = wa[7:0];
      b     = wb[7:0];
      r8    = a;
      f     = fi;
      cy    = (fn == FN_ADC || fn == FN_SBC) ? fi[FB_C] : 1'b0;
      o.fn  = fn;
      o.result = wa;
      case (fn)
        FN_ADD, FN_ADC: begin
          wide9    = {1'b0, a} + {1'b0, b} + {8'h00, cy};
          nib5     = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'h0, cy};
          r8       = wide9[7:0];
          f        = flags_szxy(r8);
          f[FB_H]  = nib5[4];
          f[FB_PV] = (a[7] ^ r8[7]) & (b[7] ^ r8[7]);
          f[FB_C]  = wide9[8];
        end
        FN_SUB, FN_SBC, FN_CP: begin
          // A borrow wraps the narrow difference negative, which sets its top bit.
          wide9    = {1'b0, a} - {1'b0, b} - {8'h00, cy};
          nib5     = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'h0, cy};
          r8       = wide9[7:0];
          f        = flags_szxy(r8);
          f[FB_N]  = 1'b1;
          f[FB_H]  = nib5[4];
          f[FB_PV] = (a[7] ^ b[7]) & (a[7] ^ r8[7]);
          f[FB_C]  = wide9[8];
          if (fn == FN_CP) begin
            f[FB_5] = b[5];
            f[FB_3] = b[3];
            r8      = a;
          end
        end
        FN_AND, FN_XOR, FN_OR: begin
          r8       = (fn == FN_AND) ? (a & b) : (fn == FN_XOR) ? (a ^ b) : (a | b);
          f        = flags_szxy(r8);
          f[FB_PV] = ~^r8;
          f[FB_H]  = (fn == FN_AND);
        end
        FN_INC: begin
          r8       = a + 8'd1;
          f        = flags_szxy(r8);
          f[FB_C]  = fi[FB_C];
          f[FB_H]  = (a[3:0] == 4'hF);
          f[FB_PV] = (a == 8'h7F);
        end
        FN_DEC: begin
          r8       = a - 8'd1;
          f        = flags_szxy(r8);
          f[FB_C]  = fi[FB_C];
          f[FB_N]  = 1'b1;
          f[FB_H]  = (a[3:0] == 4'h0);
          f[FB_PV] = (a == 8'h80);
        end
        FN_RLCA, FN_RRCA, FN_RLA, FN_RRA: begin
          case (fn)
            FN_RLCA: r8 = {a[6:0], a[7]};
            FN_RRCA: r8 = {a[0], a[7:1]};
            FN_RLA:  r8 = {a[6:0], fi[FB_C]};
            default: r8 = {fi[FB_C], a[7:1]};
          endcase
          f       = fi & FM_KEEP_SZP;
          f[FB_5] = r8[5];
          f[FB_3] = r8[3];
          f[FB_C] = (fn == FN_RLCA || fn == FN_RLA) ? a[7] : a[0];
        end
        FN_DAA: begin
          adj = 8'h00;
          if (a > 8'h99 || fi[FB_C]) adj = adj + 8'h60;
          if (a[3:0] > 4'd9 || fi[FB_H]) adj = adj + 8'h06;
          r8       = fi[FB_N] ? (a - adj) : (a + adj);
          f        = flags_szxy(r8);
          f[FB_N]  = fi[FB_N];
          f[FB_C]  = (a > 8'h99 || fi[FB_C]);
          f[FB_PV] = ~^r8;
          f[FB_H]  = a[4] ^ r8[4];
        end
        FN_CPL: begin
          r8       = ~a;
          f        = fi & FM_KEEP_SZP;
          f[FB_C]  = fi[FB_C];
          f[FB_5]  = r8[5];
          f[FB_3]  = r8[3];
          f[FB_H]  = 1'b1;
          f[FB_N]  = 1'b1;
        end
        FN_SCF, FN_CCF: begin
          r8      = a;
          f       = fi & FM_KEEP_SZP;
          f[FB_5] = a[5];
          f[FB_3] = a[3];
          f[FB_H] = (fn == FN_CCF) ? fi[FB_C] : 1'b0;
          f[FB_C] = (fn == FN_CCF) ? ~fi[FB_C] : 1'b1;
        end
        FN_ADD16: begin
          // Half carry of the wide add is the carry into bit 12.
          sum17    = {1'b0, wa} + {1'b0, wb};
          o.result = sum17[15:0];
          f        = fi & FM_KEEP_SZP;
          f[FB_5]  = sum17[13];
          f[FB_3]  = sum17[11];
          f[FB_H]  = wa[12] ^ wb[12] ^ sum17[12];
          f[FB_C]  = sum17[16];
        end
        default: begin
          f = fi;
        end
      endcase
      if (fn <= FN_CCF) o.result = {8'h00, r8};
      o.flags = f;
      return o;
    endfunction

    function void note_word(func_t fn, word_t wa, word_t wb, flag_t fi);
      pending_outcomes.push_back(predict_outcome(fn, wa, wb, fi));
      ops_seen[fn] = 1'b1;
      words_noted++;
    endfunction

    function void check_word(word_t res, flag_t fl);
      alu_outcome_t exp_o;
      if (pending_outcomes.size() == 0) begin
        $error("result word with nothing pending: result %h flags %h", res, fl);
        mismatch_cnt++;
        return;
      end
      exp_o = pending_outcomes.pop_front();
      results_checked++;
      if (res !== exp_o.result) begin
        $error("func %0d result: expected %h, actual %h", exp_o.fn, exp_o.result, res);
        mismatch_cnt++;
      end
      if (fl !== exp_o.flags) begin
        $error("func %0d flags_out: expected %b, actual %b", exp_o.fn, exp_o.flags, fl);
        mismatch_cnt++;
      end
    endfunction

    function void close_out();
      if (pending_outcomes.size() != 0) begin
        $error("%0d result words never arrived", pending_outcomes.size());
        mismatch_cnt += pending_outcomes.size();
      end
    endfunction
  endclass

  logic  clk;
  logic  rst_n;
  logic  start;
  logic  busy;
  func_t in_func;
  word_t in_operand_a;
  word_t in_operand_b;
  flag_t in_flags_in;
  logic  out_valid;
  word_t out_result;
  flag_t out_flags_out;

  alu_outcome_board board = new;
  int unsigned gap_pct;
  int unsigned directed_cnt;

  eight_bit_alu_with_flags dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_func       (in_func),
    .in_operand_a  (in_operand_a),
    .in_operand_b  (in_operand_b),
    .in_flags_in   (in_flags_in),
    .out_valid     (out_valid),
    .out_result    (out_result),
    .out_flags_out (out_flags_out)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) board.check_word(out_result, out_flags_out);
  end

  // Holds start low for random gaps, then drives the word and returns once it has been taken.
  task automatic send_word(func_t fn, word_t wa, word_t wb, flag_t fi);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start        <= 1'b1;
    in_func      <= fn;
    in_operand_a <= wa;
    in_operand_b <= wb;
    in_flags_in  <= fi;
    do @(posedge clk); while (busy !== 1'b0);
    board.note_word(fn, wa, wb, fi);
  endtask

  // Operands lean on the corners that move the carry, half carry and overflow logic.
  function automatic word_t pick_operand();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return {16'($urandom_range(16'hFFFF))} & 16'hFF00 | 16'h007F;
      3:       return {16'($urandom_range(16'hFFFF))} & 16'hFF00 | 16'h0080;
      4:       return 16'($urandom_range(16'h00FF));
      default: return 16'($urandom_range(16'hFFFF));
    endcase
  endfunction

  task automatic send_random_words(int unsigned count);
    func_t fn;
    repeat (count) begin
      if ($urandom_range(9) == 0) fn = func_t'($urandom_range(FN_LAST_UNUSED, FN_FIRST_UNUSED));
      else fn = func_t'($urandom_range(FN_ADD16));
      send_word(fn, pick_operand(), pick_operand(), flag_t'($urandom_range(8'hFF)));
    end
  endtask

  task automatic send_directed_words();
    send_word(FN_ADD,   16'h00FF, 16'h0001, 8'h00);
    send_word(FN_ADC,   16'h007F, 16'h0000, 8'h01);
    send_word(FN_SUB,   16'h0080, 16'h0001, 8'h00);
    send_word(FN_SBC,   16'h0000, 16'h00FF, 8'hFF);
    send_word(FN_AND,   16'hFFFF, 16'h0000, 8'hFF);
    send_word(FN_XOR,   16'h00AA, 16'h0055, 8'h00);
    send_word(FN_OR,    16'h0000, 16'h0000, 8'h00);
    send_word(FN_CP,    16'h1234, 16'hFF28, 8'h00);
    send_word(FN_INC,   16'h007F, 16'h0000, 8'h01);
    send_word(FN_INC,   16'h00FF, 16'h0000, 8'h00);
    send_word(FN_DEC,   16'h0080, 16'h0000, 8'h00);
    send_word(FN_DEC,   16'h0000, 16'h0000, 8'hFF);
    send_word(FN_RLCA,  16'h0081, 16'h0000, 8'hC4);
    send_word(FN_RRCA,  16'h0001, 16'h0000, 8'h00);
    send_word(FN_RLA,   16'h0080, 16'h0000, 8'h01);
    send_word(FN_RRA,   16'h0001, 16'h0000, 8'h01);
    send_word(FN_DAA,   16'h009A, 16'h0000, 8'h00);
    send_word(FN_DAA,   16'h0000, 16'h0000, 8'h13);
    send_word(FN_CPL,   16'hFF00, 16'h0000, 8'hFF);
    send_word(FN_SCF,   16'h0028, 16'h0000, 8'h00);
    send_word(FN_CCF,   16'h00FF, 16'h0000, 8'h01);
    send_word(FN_ADD16, 16'hFFFF, 16'h0001, 8'hC4);
    send_word(FN_ADD16, 16'h0FFF, 16'h0001, 8'h00);
    send_word(FN_FIRST_UNUSED, 16'hFFFF, 16'hFFFF, 8'h5A);
    send_word(FN_LAST_UNUSED,  16'h0000, 16'h0000, 8'hA5);
  endtask

  initial begin
    int unsigned guard;
    rst_n        = 1'b0;
    start        = 1'b0;
    in_func      = FN_ADD;
    in_operand_a = '0;
    in_operand_b = '0;
    in_flags_in  = '0;
    gap_pct      = 6;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    send_directed_words();
    directed_cnt = board.words_noted;
    send_random_words(WORDS_PER_PHASE);
    gap_pct = 78;
    send_random_words(WORDS_PER_PHASE);
    gap_pct = 0;
    send_random_words(WORDS_PER_PHASE);
    start <= 1'b0;

    guard = 0;
    while (board.pending_outcomes.size() != 0 && guard < 200) begin
      @(posedge clk);
      guard++;
    end
    repeat (4) @(posedge clk);
    board.close_out();

    $display("Covered %0d words (%0d directed), %0d results checked, %0d of 32 func codes.",
             board.words_noted, directed_cnt, board.results_checked, $countones(board.ops_seen));
    $display("Sender gaps ran at 6%%, 78%% and 0%% of cycles; all flag bits random.");
    if (board.mismatch_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
